// ===== sv/rbp_pkg.sv =====
// ----------------------------------------------------------------------------
// rbp_pkg: shared types and constants of the reconnect backoff policy
// Event, result and queue entry layouts, register indexes and reset values.
// ----------------------------------------------------------------------------
package rbp_pkg;

  // event kinds
  typedef enum logic [1:0] {
    ActStart      = 2'd0,
    ActDisconnect = 2'd1,
    ActAddrGained = 2'd2,
    ActAddrLost   = 2'd3
  } action_e;

  // commands handed back
  typedef enum logic [1:0] {
    CmdNone    = 2'd0,
    CmdConnect = 2'd1,
    CmdRestart = 2'd2,
    CmdGiveUp  = 2'd3
  } command_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    RegRetryLimit     = 3'd0,
    RegForceResetFail = 3'd1,
    RegCooldownFail   = 3'd2,
    RegBackoffBase    = 3'd3,
    RegBackoffCap     = 3'd4,
    RegComebackCap    = 3'd5,
    RegComebackWindow = 3'd6,
    RegCooldownWindow = 3'd7
  } reg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // restart budget and shift limit of the backoff
  localparam logic [3:0] RestartBudget = 4'd3;
  localparam logic [7:0] ShiftLimit    = 8'd10;

  // default queue depth between front and back
  localparam int unsigned QueueDepthDefault = 2;

  // register reset values
  localparam logic [7:0]  RetryLimitRst     = 8'd10;
  localparam logic [7:0]  ForceResetFailRst = 8'd6;
  localparam logic [7:0]  CooldownFailRst   = 8'd3;
  localparam logic [15:0] BackoffBaseRst    = 16'd500;
  localparam logic [31:0] BackoffCapRst     = 32'd30000;
  localparam logic [31:0] ComebackCapRst    = 32'd5000;
  localparam logic [31:0] ComebackWinRst    = 32'd60000;
  localparam logic [31:0] CooldownWinRst    = 32'd120000;

  typedef struct packed {
    logic [7:0]  retry_limit;
    logic [7:0]  force_reset_fails;
    logic [7:0]  cooldown_fails;
    logic [15:0] backoff_base_ms;
    logic [31:0] backoff_cap_ms;
    logic [31:0] comeback_cap_ms;
    logic [31:0] comeback_window_ms;
    logic [31:0] cooldown_window_ms;
  } cfg_t;

  typedef struct packed {
    action_e     action;
    logic [31:0] now_ms;
    logic        restart_ok;
  } in_t;

  typedef struct packed {
    command_e    command;
    logic [31:0] delay_ms;
    logic        link_up;
    logic        link_failed;
  } out_t;

  // classified event waiting for the delay stage
  typedef struct packed {
    command_e   command;
    logic [7:0] eff_fails;
    logic       comeback;
    logic       link_up;
    logic       link_failed;
  } job_t;

endpackage

// ===== sv/reconnect_backoff_policy.sv =====
// ----------------------------------------------------------------------------
// reconnect_backoff_policy: link reconnect policy with capped backoff
// Decides per link event whether to reconnect after a delay, restart the
// radio or give up, and reports link status.
//
//   channel  direction  handshake                  payload
//   event    in         push_i / full_o            in_i  (action, now_ms, restart_ok)
//   result   out        pop_i / empty_o            out_o (command, delay_ms, status)
//   config   in         cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One event per cycle is accepted while full_o is low; its result passes
// through the queue entry, then the delay stage into the result register,
// before it shows on the result ports.
// The decision stage updates all policy state in the accept cycle, so
// events follow each other without gaps.
// Reset clears counts, status and queue; registers take their defaults.
// A held result stalls the delay stage; events keep coming until the queue
// of QueueDepth entries fills, then full_o rises.
// ----------------------------------------------------------------------------
module reconnect_backoff_policy #(
  parameter int unsigned QueueDepth = rbp_pkg::QueueDepthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  output logic                         full_o,
  input  rbp_pkg::in_t                 in_i,
  input  logic                         pop_i,
  output logic                         empty_o,
  output rbp_pkg::out_t                out_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [rbp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rbp_pkg::CfgDataW-1:0] cfg_data_i
);
  import rbp_pkg::*;

  cfg_t cfg_q;
  job_t front_job, queue_job;
  logic accept;
  logic queue_valid, queue_take;

  assign cfg_ready_o = 1'b1;
  assign accept      = push_i && !full_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.retry_limit        <= RetryLimitRst;
      cfg_q.force_reset_fails  <= ForceResetFailRst;
      cfg_q.cooldown_fails     <= CooldownFailRst;
      cfg_q.backoff_base_ms    <= BackoffBaseRst;
      cfg_q.backoff_cap_ms     <= BackoffCapRst;
      cfg_q.comeback_cap_ms    <= ComebackCapRst;
      cfg_q.comeback_window_ms <= ComebackWinRst;
      cfg_q.cooldown_window_ms <= CooldownWinRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        RegRetryLimit:     cfg_q.retry_limit        <= cfg_data_i[7:0];
        RegForceResetFail: cfg_q.force_reset_fails  <= cfg_data_i[7:0];
        RegCooldownFail:   cfg_q.cooldown_fails     <= cfg_data_i[7:0];
        RegBackoffBase:    cfg_q.backoff_base_ms    <= cfg_data_i[15:0];
        RegBackoffCap:     cfg_q.backoff_cap_ms     <= cfg_data_i;
        RegComebackCap:    cfg_q.comeback_cap_ms    <= cfg_data_i;
        RegComebackWindow: cfg_q.comeback_window_ms <= cfg_data_i;
        default:           cfg_q.cooldown_window_ms <= cfg_data_i;
      endcase
    end
  end

  // decision stage
  rbp_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .evt_i    (in_i),
    .cfg_i    (cfg_q),
    .job_o    (front_job)
  );

  // job queue
  rbp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (accept),
    .wr_data_i (front_job),
    .full_o    (full_o),
    .rd_i      (queue_take),
    .valid_o   (queue_valid),
    .rd_data_o (queue_job)
  );

  // delay stage and result register
  rbp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (queue_valid),
    .job_i       (queue_job),
    .job_take_o  (queue_take),
    .cfg_i       (cfg_q),
    .pop_i       (pop_i),
    .empty_o     (empty_o),
    .out_o       (out_o)
  );

endmodule

// ===== sv/rbp_front.sv =====
// ----------------------------------------------------------------------------
// rbp_front: event intake and policy decision
// Keeps the failure, retry and restart counts and the last success time,
// picks the command for each event and queues it for the delay stage.
// ----------------------------------------------------------------------------
module rbp_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  rbp_pkg::in_t  evt_i,
  input  rbp_pkg::cfg_t cfg_i,
  output rbp_pkg::job_t job_o
);
  import rbp_pkg::*;

  logic [7:0]  fail_q, fail_d;
  logic [7:0]  retry_q, retry_d;
  logic [3:0]  restart_q, restart_d;
  logic [31:0] good_time_q, good_time_d;
  logic        good_valid_q, good_valid_d;
  logic        up_q, up_d;
  logic        failed_q, failed_d;

  logic [7:0]  fail_inc;
  logic [7:0]  retry_inc;
  logic [31:0] elapsed;
  logic        in_comeback;
  logic        in_cooldown;
  logic        force_rst;

  // saturating increments and time since last success
  assign fail_inc    = (fail_q == 8'hFF) ? fail_q : fail_q + 8'd1;
  assign retry_inc   = (retry_q == 8'hFF) ? retry_q : retry_q + 8'd1;
  assign elapsed     = evt_i.now_ms - good_time_q;
  assign in_comeback = good_valid_q && (elapsed <= cfg_i.comeback_window_ms);
  assign in_cooldown = good_valid_q && (elapsed >= cfg_i.cooldown_window_ms);
  assign force_rst   = (fail_inc >= cfg_i.force_reset_fails) ||
                       ((fail_inc >= cfg_i.cooldown_fails) && in_cooldown);

  // policy decision for the current event
  always_comb begin
    fail_d       = fail_q;
    retry_d      = retry_q;
    restart_d    = restart_q;
    good_time_d  = good_time_q;
    good_valid_d = good_valid_q;
    up_d         = up_q;
    failed_d     = failed_q;
    job_o.command   = CmdNone;
    job_o.eff_fails = fail_q;
    job_o.comeback  = 1'b0;

    unique case (evt_i.action)
      ActStart: begin
        job_o.command = CmdConnect;
      end
      ActDisconnect: begin
        fail_d  = fail_inc;
        retry_d = retry_inc;
        up_d    = 1'b0;
        job_o.command  = CmdConnect;
        job_o.comeback = in_comeback;
        if (in_comeback) begin
          job_o.eff_fails = (fail_inc > 8'd1) ? fail_inc - 8'd1 : 8'd1;
        end else begin
          job_o.eff_fails = fail_inc;
        end
        if (retry_inc >= cfg_i.retry_limit) begin
          failed_d      = 1'b1;
          job_o.command = CmdGiveUp;
        end else if (force_rst && (restart_q < RestartBudget)) begin
          restart_d = restart_q + 4'd1;
          if (evt_i.restart_ok) begin
            fail_d        = 8'd0;
            job_o.command = CmdRestart;
          end
        end
      end
      ActAddrGained: begin
        fail_d       = 8'd0;
        retry_d      = 8'd0;
        restart_d    = 4'd0;
        good_time_d  = evt_i.now_ms;
        good_valid_d = 1'b1;
        failed_d     = 1'b0;
        up_d         = 1'b1;
      end
      default: begin
        up_d = 1'b0;
      end
    endcase

    job_o.link_up     = up_d;
    job_o.link_failed = failed_d;
  end

  // policy state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fail_q       <= '0;
      retry_q      <= '0;
      restart_q    <= '0;
      good_time_q  <= '0;
      good_valid_q <= 1'b0;
      up_q         <= 1'b0;
      failed_q     <= 1'b0;
    end else if (accept_i) begin
      fail_q       <= fail_d;
      retry_q      <= retry_d;
      restart_q    <= restart_d;
      good_time_q  <= good_time_d;
      good_valid_q <= good_valid_d;
      up_q         <= up_d;
      failed_q     <= failed_d;
    end
  end

endmodule

// ===== sv/rbp_queue.sv =====
// ----------------------------------------------------------------------------
// rbp_queue: short job queue between decision and delay stages
// Circular buffer with read and write pointers and an entry count.
// ----------------------------------------------------------------------------
module rbp_queue #(
  parameter int unsigned Depth = rbp_pkg::QueueDepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  rbp_pkg::job_t wr_data_i,
  output logic          full_o,
  input  logic          rd_i,
  output logic          valid_o,
  output rbp_pkg::job_t rd_data_o
);
  import rbp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  job_t            entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_wr, do_rd;

  assign full_o    = (count_q == FullCnt);
  assign valid_o   = (count_q != '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && valid_o;
  assign rd_data_o = entries_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      entries_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + CntW'(1);
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

// ===== sv/rbp_back.sv =====
// ----------------------------------------------------------------------------
// rbp_back: backoff delay stage and result register
// Shifts the base delay by the effective failure count less one, applies the cap and holds
// the result until it is taken.
// ----------------------------------------------------------------------------
module rbp_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  rbp_pkg::job_t job_i,
  output logic          job_take_o,
  input  rbp_pkg::cfg_t cfg_i,
  input  logic          pop_i,
  output logic          empty_o,
  output rbp_pkg::out_t out_o
);
  import rbp_pkg::*;

  logic        out_valid_q;
  out_t        out_q, out_d;
  logic [7:0]  shift_full;
  logic [3:0]  shift_amt;
  logic [31:0] shifted;
  logic [31:0] cap;

  // shift amount clipped to the limit
  assign shift_full = job_i.eff_fails - 8'd1;
  assign shift_amt  = (shift_full > ShiftLimit) ? ShiftLimit[3:0] : shift_full[3:0];
  assign shifted    = {16'd0, cfg_i.backoff_base_ms} << shift_amt;
  assign cap        = job_i.comeback ? cfg_i.comeback_cap_ms : cfg_i.backoff_cap_ms;

  // result assembly
  always_comb begin
    out_d.command     = job_i.command;
    out_d.link_up     = job_i.link_up;
    out_d.link_failed = job_i.link_failed;
    out_d.delay_ms    = '0;
    if ((job_i.command == CmdConnect) && (job_i.eff_fails != 8'd0)) begin
      out_d.delay_ms = (shifted > cap) ? cap : shifted;
    end
  end

  assign job_take_o = job_valid_i && (!out_valid_q || pop_i);
  assign empty_o    = !out_valid_q;
  assign out_o      = out_q;

  // result data
  always_ff @(posedge clk_i) begin
    if (job_take_o) begin
      out_q <= out_d;
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (job_take_o) begin
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

endmodule
